### src/shp_pkg.sv
// ----------------------------------------------------------------------------
// shp_pkg: shared types and constants for the stepper homing block
// Phase codes, item kinds, status codes and controller/datapath interface.
// ----------------------------------------------------------------------------
package shp_pkg;

    localparam int PosW = 16;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_HOME = 2'd1;
    localparam logic [1:0] KIND_MOVE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_HOMEERR = 2'd2;

    localparam logic [1:0] CFG_TOTAL = 2'd0;
    localparam logic [1:0] CFG_FAST  = 2'd1;
    localparam logic [1:0] CFG_SLOW  = 2'd2;
    localparam logic [1:0] CFG_ADJ   = 2'd3;

    // ceil(2^30/45) and ceil(2^32/225): exact quotients over the operand ranges
    localparam logic [24:0] RECIP_45  = 25'd23860930;
    localparam logic [24:0] RECIP_225 = 25'd19088744;

    typedef enum logic [2:0] {
        PH_IDLE, PH_LEAVE_FAST, PH_SEEK_FAST, PH_LEAVE_SLOW,
        PH_BACK_ON, PH_BACK_OFF, PH_CENTER, PH_ADJUST
    } phase_t;

    // operand source for the shared multiply/divide
    typedef enum logic [2:0] {
        SRC_D370, SRC_D30, SRC_DM35, SRC_ADJ, SRC_TENTHS
    } src_t;

    typedef struct packed {
        logic   calc_start;  // start multiply+divide
        src_t   src;
        logic   load_calc;   // load move from calc result (degree form)
        logic   load_move;   // load shortest-path move from calc result
        logic   load_center; // load half switch width move
        logic   try_step;
        logic   set_slow;
        logic   clr_slow;
        logic   rec_end;
        logic   zero_pos;
        logic   home_clear;
    } cmd_t;

    typedef struct packed {
        logic calc_done;
        logic rem_zero;
        logic stepped;
        logic mod_busy;
    } sts_t;

endpackage

### src/shp_datapath.sv
// ----------------------------------------------------------------------------
// shp_datapath: position, move and step arithmetic
// Multiplies angle by total steps, divides by 360 or 3600 with a shift and a
// reciprocal multiply, normalizes and steps. A change of total steps reduces
// the stored position with a serial remainder.
// ----------------------------------------------------------------------------
module shp_datapath import shp_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [15:0]       total_steps,
    input  logic [7:0]        fast_iv,
    input  logic [7:0]        slow_iv,
    input  logic signed [8:0] adj_deg,
    input  logic signed [12:0] tenths,
    output logic [15:0]       position,
    output logic              move_cw
);

    logic [15:0] pos_reg, pos_next;
    logic [15:0] cur_reg, cur_next;   // pos_reg reduced modulo tot
    logic [15:0] rem_reg, rem_next;
    logic        cw_reg, cw_next;
    logic [7:0]  ivc_reg, ivc_next;
    logic        slow_reg, slow_next;
    logic [15:0] end_reg, end_next;
    logic [15:0] endr_reg, endr_next; // end_reg reduced modulo tot

    // constant divider
    logic [28:0] dvd_reg;     // magnitude of product
    logic        dneg_reg, dten_reg;
    logic        d1_reg, ddone_reg;
    logic [16:0] qmag_reg;

    // position remainder unit
    logic        mbusy_reg;
    logic [4:0]  mcnt_reg;
    logic [15:0] totc_reg;
    logic [15:0] mrp_reg, mre_reg, mdp_reg, mde_reg;

    logic [15:0] tot;
    assign tot = (total_steps == 16'd0) ? 16'd1 : total_steps;

    logic [15:0] cur;
    assign cur = cur_reg;

    logic signed [12:0] opnd;
    always_comb begin
        opnd = 13'sd0;
        case (cmd.src)
            SRC_D370:   opnd = 13'sd370;
            SRC_D30:    opnd = 13'sd30;
            SRC_DM35:   opnd = -13'sd35;
            SRC_ADJ:    opnd = 13'(adj_deg);
            SRC_TENTHS: opnd = tenths;
            default:    opnd = 13'sd0;
        endcase
    end

    logic signed [29:0] prod;
    logic [12:0]        omag;
    assign omag = opnd[12] ? 13'(-opnd) : 13'(opnd);
    assign prod = 30'(omag) * 30'(tot);

    // x/360 = (x>>3)/45, x/3600 = (x>>4)/225
    logic [23:0] rn;
    logic [24:0] rm;
    logic [48:0] rp;
    logic [16:0] rq;
    assign rn = dten_reg ? dvd_reg[27:4] : {2'b00, dvd_reg[24:3]};
    assign rm = dten_reg ? RECIP_225 : RECIP_45;
    assign rp = 49'(rn) * 49'(rm);
    assign rq = dten_reg ? rp[48:32] : rp[46:30];

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            d1_reg    <= 1'b0;
            ddone_reg <= 1'b0;
        end else begin
            d1_reg    <= cmd.calc_start;
            ddone_reg <= d1_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.calc_start) begin
            dvd_reg  <= prod[28:0];
            dneg_reg <= opnd[12];
            dten_reg <= (cmd.src == SRC_TENTHS);
        end
        if (d1_reg) qmag_reg <= rq;
    end

    logic [17:0] mtp, mte;
    logic [15:0] mrp_step, mre_step;
    logic        mod_fin;
    assign mtp      = {1'b0, mrp_reg, mdp_reg[15]} - {2'b00, totc_reg};
    assign mte      = {1'b0, mre_reg, mde_reg[15]} - {2'b00, totc_reg};
    assign mrp_step = mtp[17] ? {mrp_reg[14:0], mdp_reg[15]} : mtp[15:0];
    assign mre_step = mte[17] ? {mre_reg[14:0], mde_reg[15]} : mte[15:0];
    assign mod_fin  = mbusy_reg && (mcnt_reg == 5'd1);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mbusy_reg <= 1'b0;
            mcnt_reg  <= '0;
            totc_reg  <= 16'd4096;
            mrp_reg   <= '0;
            mre_reg   <= '0;
            mdp_reg   <= '0;
            mde_reg   <= '0;
        end else if (mbusy_reg) begin
            mcnt_reg <= mcnt_reg - 5'd1;
            mrp_reg  <= mrp_step;
            mre_reg  <= mre_step;
            mdp_reg  <= {mdp_reg[14:0], 1'b0};
            mde_reg  <= {mde_reg[14:0], 1'b0};
            if (mcnt_reg == 5'd1) mbusy_reg <= 1'b0;
        end else if (tot != totc_reg) begin
            mbusy_reg <= 1'b1;
            mcnt_reg  <= 5'd16;
            totc_reg  <= tot;
            mrp_reg   <= '0;
            mre_reg   <= '0;
            mdp_reg   <= pos_reg;
            mde_reg   <= end_reg;
        end
    end

    // quotient magnitude fits 17 bits (370*65535/360 < 2^17)
    logic [16:0] qmag;
    assign qmag = qmag_reg;
    logic [16:0] qsat;
    assign qsat = qmag;

    // move target: |target| < 2*tot, so one subtraction reduces it
    logic [16:0] qred;
    logic [16:0] tgt;
    always_comb begin
        qred = (qmag >= 17'(tot)) ? qmag - 17'(tot) : qmag;
        if (dneg_reg && qred != 17'd0)
            tgt = 17'(tot) - qred;
        else
            tgt = qred;
    end

    logic [16:0] cw_d, ccw_d;
    always_comb begin
        cw_d  = (tgt >= 17'(cur)) ? tgt - 17'(cur) : tgt + 17'(tot) - 17'(cur);
        ccw_d = (17'(cur) >= tgt) ? 17'(cur) - tgt : 17'(cur) + 17'(tot) - tgt;
    end

    logic [15:0] width;
    always_comb begin
        width = (endr_reg >= cur) ? endr_reg - cur
                                  : 16'(17'(endr_reg) + 17'(tot) - 17'(cur));
    end

    logic [7:0] iv;
    logic [7:0] ivc_inc;
    assign iv = (slow_reg ? slow_iv : fast_iv) == 8'd0 ? 8'd1 : (slow_reg ? slow_iv : fast_iv);
    assign ivc_inc = ivc_reg + 8'd1;

    logic stepped;
    always_comb begin
        pos_next  = pos_reg;
        cur_next  = cur_reg;
        rem_next  = rem_reg;
        cw_next   = cw_reg;
        ivc_next  = ivc_reg;
        slow_next = slow_reg;
        end_next  = end_reg;
        endr_next = endr_reg;
        stepped   = 1'b0;
        if (mod_fin) begin
            cur_next  = mrp_step;
            endr_next = mre_step;
        end
        if (cmd.set_slow) slow_next = 1'b1;
        if (cmd.clr_slow) slow_next = 1'b0;
        if (cmd.rec_end) begin
            end_next  = cur;
            endr_next = cur;
        end
        if (cmd.load_calc) begin
            cw_next  = !dneg_reg && qmag != 17'd0;
            rem_next = (qsat > 17'd65535) ? 16'hFFFF : qsat[15:0];
            ivc_next = '0;
        end
        if (cmd.load_move) begin
            ivc_next = '0;
            if (cw_d <= ccw_d) begin
                cw_next  = cw_d != 17'd0;
                rem_next = cw_d[15:0];
            end else begin
                cw_next  = 1'b0;
                rem_next = ccw_d[15:0];
            end
        end
        if (cmd.load_center) begin
            ivc_next = '0;
            rem_next = {1'b0, width[15:1]};
            cw_next  = width[15:1] != 15'd0;
        end
        if (cmd.try_step) begin
            ivc_next = ivc_inc;
            if (ivc_inc >= iv) begin
                ivc_next = '0;
                stepped  = 1'b1;
                rem_next = rem_reg - 16'd1;
                if (cw_reg)
                    pos_next = (17'(cur) + 17'd1 >= 17'(tot)) ? 16'd0 : cur + 16'd1;
                else
                    pos_next = (cur == 16'd0) ? tot - 16'd1 : cur - 16'd1;
            end
        end
        if (cmd.zero_pos) pos_next = '0;
        if (cmd.home_clear) begin
            pos_next  = '0;
            slow_next = 1'b0;
        end
        // every datapath write leaves the position already reduced
        if (stepped || cmd.zero_pos || cmd.home_clear) cur_next = pos_next;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pos_reg  <= '0;
            cur_reg  <= '0;
            rem_reg  <= '0;
            cw_reg   <= 1'b0;
            ivc_reg  <= '0;
            slow_reg <= 1'b0;
            end_reg  <= '0;
            endr_reg <= '0;
        end else begin
            pos_reg  <= pos_next;
            cur_reg  <= cur_next;
            rem_reg  <= rem_next;
            cw_reg   <= cw_next;
            ivc_reg  <= ivc_next;
            slow_reg <= slow_next;
            end_reg  <= end_next;
            endr_reg <= endr_next;
        end
    end

    assign sts.calc_done = ddone_reg;
    assign sts.rem_zero  = rem_reg == 16'd0;
    assign sts.stepped   = stepped;
    assign sts.mod_busy  = mbusy_reg || (tot != totc_reg);
    assign position = cur_reg;
    assign move_cw  = cw_reg;

endmodule

### src/shp_ctrl.sv
// ----------------------------------------------------------------------------
// shp_ctrl: homing phase sequencer and transaction control
// Accepts one item, issues datapath commands, waits for arithmetic, and
// holds the result in an output register until taken.
// ----------------------------------------------------------------------------
module shp_ctrl import shp_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] kind,
    input  logic       switch_active,
    output logic       out_valid,
    input  logic       out_ready,
    output cmd_t       cmd,
    input  sts_t       sts,
    output logic       pulse,
    output logic       homed,
    output logic       busy,
    output logic [1:0] status_code
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CALC = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    phase_t ph_reg, ph_next;
    logic   homed_reg, homed_next;
    logic   err_reg, err_next;
    logic   pulse_reg, pulse_next;
    logic   ref_reg, ref_next;
    logic   mv_reg, mv_next; // pending calc is an absolute move

    logic accept;
    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !sts.mod_busy;

    always_comb begin
        cmd        = '0;
        cmd.src    = SRC_D370;
        state_next = state_reg;
        ph_next    = ph_reg;
        homed_next = homed_reg;
        err_next   = err_reg;
        pulse_next = pulse_reg;
        ref_next   = ref_reg;
        mv_next    = mv_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    pulse_next = 1'b0;
                    ref_next   = 1'b0;
                    mv_next    = 1'b0;
                    state_next = S_OUT;
                    case (kind)
                        KIND_TICK: begin
                            case (ph_reg)
                                PH_IDLE: cmd.try_step = !sts.rem_zero;
                                PH_CENTER: begin
                                    if (!sts.rem_zero) cmd.try_step = 1'b1;
                                    else begin
                                        ph_next = PH_ADJUST;
                                        cmd.calc_start = 1'b1;
                                        cmd.src = SRC_ADJ;
                                        state_next = S_CALC;
                                    end
                                end
                                PH_ADJUST: begin
                                    if (!sts.rem_zero) cmd.try_step = 1'b1;
                                    else begin
                                        cmd.zero_pos = 1'b1;
                                        homed_next = 1'b1;
                                        ph_next = PH_IDLE;
                                    end
                                end
                                default: begin
                                    if (switch_active ==
                                        (ph_reg == PH_SEEK_FAST || ph_reg == PH_BACK_ON)) begin
                                        case (ph_reg)
                                            PH_LEAVE_FAST: begin
                                                ph_next = PH_SEEK_FAST;
                                                cmd.calc_start = 1'b1;
                                                cmd.src = SRC_D370;
                                                state_next = S_CALC;
                                            end
                                            PH_SEEK_FAST: begin
                                                ph_next = PH_LEAVE_SLOW;
                                                cmd.set_slow = 1'b1;
                                                cmd.calc_start = 1'b1;
                                                cmd.src = SRC_D30;
                                                state_next = S_CALC;
                                            end
                                            PH_LEAVE_SLOW: begin
                                                cmd.rec_end = 1'b1;
                                                ph_next = PH_BACK_ON;
                                                cmd.calc_start = 1'b1;
                                                cmd.src = SRC_DM35;
                                                state_next = S_CALC;
                                            end
                                            PH_BACK_ON: begin
                                                ph_next = PH_BACK_OFF;
                                                cmd.calc_start = 1'b1;
                                                cmd.src = SRC_DM35;
                                                state_next = S_CALC;
                                            end
                                            default: begin
                                                ph_next = PH_CENTER;
                                                cmd.clr_slow = 1'b1;
                                                cmd.load_center = 1'b1;
                                            end
                                        endcase
                                    end else if (sts.rem_zero) begin
                                        err_next = 1'b1;
                                        ph_next = PH_IDLE;
                                        cmd.clr_slow = 1'b1;
                                    end else begin
                                        cmd.try_step = 1'b1;
                                    end
                                end
                            endcase
                            pulse_next = sts.stepped;
                        end
                        KIND_HOME: begin
                            cmd.home_clear = 1'b1;
                            homed_next = 1'b0;
                            err_next = 1'b0;
                            ph_next = PH_LEAVE_FAST;
                            cmd.calc_start = 1'b1;
                            cmd.src = SRC_D370;
                            state_next = S_CALC;
                        end
                        KIND_MOVE: begin
                            if (!homed_reg) ref_next = 1'b1;
                            else begin
                                mv_next = 1'b1;
                                cmd.calc_start = 1'b1;
                                cmd.src = SRC_TENTHS;
                                state_next = S_CALC;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_CALC: begin
                if (sts.calc_done) begin
                    if (mv_reg) cmd.load_move = 1'b1;
                    else        cmd.load_calc = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            ph_reg    <= PH_IDLE;
            homed_reg <= 1'b0;
            err_reg   <= 1'b0;
            pulse_reg <= 1'b0;
            ref_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            homed_reg <= homed_next;
            err_reg   <= err_next;
            pulse_reg <= pulse_next;
            ref_reg   <= ref_next;
            mv_reg    <= mv_next;
        end
    end

    assign out_valid   = (state_reg == S_OUT);
    assign pulse       = pulse_reg;
    assign homed       = homed_reg;
    assign busy        = (ph_reg != PH_IDLE) || !sts.rem_zero;
    assign status_code = ref_reg ? ST_REFUSED : (err_reg ? ST_HOMEERR : ST_OK);

endmodule

### src/stepper_home_and_position.sv
// ----------------------------------------------------------------------------
// stepper_home_and_position: homing and shortest-path positioning of a stepper
// Items that start a calculation pass through product, reciprocal multiply and
// load before the result is valid; other items go straight to the result state.
// Throughput: one transaction at a time; next item accepted once the result is
// taken and no reduction runs. A total_steps write holds off input while the
// position is reduced. Reset: control state cleared, config registers to defaults.
// ----------------------------------------------------------------------------
module stepper_home_and_position import shp_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic               switch_active,
    input  logic signed [12:0] target_tenths,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               step_pulse,
    output logic               step_clockwise,
    output logic [15:0]        position,
    output logic               homed,
    output logic               busy_res,
    output logic [1:0]         status
);

    logic [15:0]       total_reg;
    logic [7:0]        fast_reg, slow_reg;
    logic signed [8:0] adj_reg;
    logic signed [12:0] tenths_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            total_reg <= 16'd4096;
            fast_reg  <= 8'd1;
            slow_reg  <= 8'd4;
            adj_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_TOTAL: total_reg <= cfg_data;
                CFG_FAST:  fast_reg  <= cfg_data[7:0];
                CFG_SLOW:  slow_reg  <= cfg_data[7:0];
                CFG_ADJ:   adj_reg   <= cfg_data[8:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready) tenths_reg <= target_tenths;
    end

    cmd_t cmd;
    sts_t sts;
    logic [12:0] tenths_mux;
    assign tenths_mux = (in_valid && in_ready) ? target_tenths : tenths_reg;

    shp_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .kind, .switch_active,
        .out_valid, .out_ready, .cmd, .sts,
        .pulse(step_pulse), .homed, .busy(busy_res), .status_code(status)
    );

    shp_datapath u_dp (
        .clk, .rst_n, .cmd, .sts,
        .total_steps(total_reg), .fast_iv(fast_reg), .slow_iv(slow_reg),
        .adj_deg(adj_reg), .tenths(tenths_mux),
        .position, .move_cw(step_clockwise)
    );

    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_out_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        status != 2'd3) else $error("bad status");

endmodule
